FILE: rtl/bba_pkg.sv
// Shared constants and types for the bitmap block allocator.
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned MaxBlocks  = 4096;
  localparam int unsigned WordW      = 32;
  localparam int unsigned Rows       = MaxBlocks / WordW;
  localparam int unsigned RowW       = $clog2(Rows);
  localparam int unsigned BitW       = $clog2(WordW);
  localparam int unsigned CountW     = 13;
  localparam int unsigned ReqW       = 5;
  localparam int unsigned IdxW       = 12;

  localparam logic [CountW-1:0] MaxBlocksC  = CountW'(MaxBlocks);
  localparam logic [ReqW-1:0]   MaxRequestC = ReqW'(16);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef logic [WordW-1:0] word_t;

  // one write port and one read port per cycle
  typedef struct packed {
    logic            we;
    logic [RowW-1:0] waddr;
    word_t           wdata;
    logic            re;
    logic [RowW-1:0] raddr;
  } ram_req_t;

endpackage

FILE: rtl/bba_ram.sv
// Occupancy bitmap storage: one word per row, registered read data.
`timescale 1ns / 1ps
module bba_ram (
  input  logic              clk_i,
  input  bba_pkg::ram_req_t req_i,
  output bba_pkg::word_t    rdata_o
);
  import bba_pkg::*;

  word_t mem [Rows];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bitmap_block_allocator_top.sv
// First-fit block allocator over a word-organized occupancy bitmap.
//
//  channel   | dir | payload
//  s_axis    | in  | tdata[4:0] request_count, [16:5] block_index; tuser[1:0] op
//  m_axis    | out | tdata[12:0] block_number, tuser granted, tlast last
//  cfg       | in  | data[12:0] blocks_in_use
//
// Allocate: accept, then for each 32-bit bitmap row visited read the row and scan it,
// granting one block at a time, then close out. Bounded by the read-modify-write of
// one RAM row at a time. Free and clear write back at most one row, none when no row
// needs a write. One item at a time; grants after the first and the close-out stall
// while the output register is full. Reset clears a per-row valid bit, so no
// clearing pass is needed; an invalid row reads as all free.
`timescale 1ns / 1ps
module bitmap_block_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // request_count[4:0], block_index[16:5]
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // block_number[12:0]
  output logic        m_axis_tuser_o,   // granted[0]
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i
);
  import bba_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e            state_q;
  op_e               op_q;
  logic [CountW-1:0] cfg_q;
  logic [RowW-1:0]   row_q;
  logic [BitW-1:0]   bit_q;
  logic [ReqW-1:0]   want_q;
  word_t             word_q;
  logic [Rows-1:0]   valid_q;
  logic              pend_q;
  logic [CountW-1:0] pend_num_q;
  logic              out_valid_q;
  logic [CountW-1:0] out_num_q;
  logic              out_grant_q;
  logic              out_last_q;

  op_e               in_op;
  logic [ReqW-1:0]   in_req;
  logic [IdxW-1:0]   in_idx;
  logic [CountW-1:0] n_eff;
  logic              in_acc;
  logic              out_free;
  logic              out_load;
  word_t             rdata;
  word_t             word_in;
  word_t             lim_mask;
  word_t             cand;
  logic [BitW-1:0]   pos;
  logic              grant_go;
  logic              scan_end;
  logic              last_row;
  logic              scan_stop;
  logic [RowW:0]     row_next;
  logic [ReqW-1:0]   want_init;
  ram_req_t          ram_req;

  assign in_op    = op_e'(s_axis_tuser_i);
  assign in_req   = s_axis_tdata_i[4:0];
  assign in_idx   = s_axis_tdata_i[16:5];
  assign n_eff    = (cfg_q > MaxBlocksC) ? MaxBlocksC : cfg_q;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o = 1'b1;
  assign want_init = (in_req > MaxRequestC) ? MaxRequestC : in_req;

  assign word_in = valid_q[row_q] ? rdata : '0;

  // bits of the current row that lie below the managed block count
  always_comb begin
    if ({1'b0, row_q} < n_eff[CountW-1:BitW]) begin
      lim_mask = '1;
    end else if ({1'b0, row_q} == n_eff[CountW-1:BitW]) begin
      lim_mask = (word_t'(1) << n_eff[BitW-1:0]) - word_t'(1);
    end else begin
      lim_mask = '0;
    end
  end

  assign cand = ~word_q & lim_mask;

  always_comb begin
    pos = '0;
    for (int b = WordW - 1; b >= 0; b--) begin
      if (cand[b]) begin
        pos = BitW'(b);
      end
    end
  end

  assign row_next  = {1'b0, row_q} + (RowW+1)'(1);
  assign last_row  = {row_next, {BitW{1'b0}}} >= n_eff;
  assign grant_go  = (state_q == ST_SCAN) && (want_q != '0) && (cand != '0)
                     && (!pend_q || out_free);
  assign scan_end  = (state_q == ST_SCAN) && !((want_q != '0) && (cand != '0));
  assign scan_stop = (want_q == '0) || last_row;
  assign out_load  = (grant_go && pend_q) || ((state_q == ST_DONE) && out_free);

  always_comb begin
    ram_req = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ram_req.re = 1'b1;
          case (in_op)
            OP_FREE:  ram_req.raddr = in_idx[IdxW-1:BitW];
            OP_CLEAR: ram_req.raddr = n_eff[RowW+BitW-1:BitW];
            default:  ram_req.raddr = '0;
          endcase
        end
      end
      ST_LOAD: begin
        if (op_q == OP_FREE || op_q == OP_CLEAR) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = row_q;
          if (op_q == OP_FREE) begin
            ram_req.wdata = word_in & ~(word_t'(1) << bit_q);
          end else begin
            ram_req.wdata = word_in & ~((word_t'(1) << bit_q) - word_t'(1));
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = row_q;
          ram_req.wdata = word_q;
          if (!scan_stop) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = row_next[RowW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  bba_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NONE;
      cfg_q       <= MaxBlocksC;
      row_q       <= '0;
      bit_q       <= '0;
      want_q      <= '0;
      word_q      <= '0;
      valid_q     <= '0;
      pend_q      <= 1'b0;
      pend_num_q  <= '0;
      out_valid_q <= 1'b0;
      out_num_q   <= '0;
      out_grant_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ram_req.we) begin
        valid_q[ram_req.waddr] <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q <= in_op;
            case (in_op)
              OP_ALLOC: begin
                row_q   <= '0;
                want_q  <= want_init;
                state_q <= ST_LOAD;
              end
              OP_FREE: begin
                row_q <= in_idx[IdxW-1:BitW];
                bit_q <= in_idx[BitW-1:0];
                if ({1'b0, in_idx} < n_eff) begin
                  state_q <= ST_LOAD;
                end
              end
              OP_CLEAR: begin
                // whole rows below the count drop to free at once
                for (int r = 0; r < Rows; r++) begin
                  if ((RowW+1)'(r) < n_eff[CountW-1:BitW]) begin
                    valid_q[r] <= 1'b0;
                  end
                end
                row_q <= n_eff[RowW+BitW-1:BitW];
                bit_q <= n_eff[BitW-1:0];
                if (n_eff[BitW-1:0] != '0) begin
                  state_q <= ST_LOAD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          word_q <= word_in;
          if (op_q == OP_ALLOC) begin
            state_q <= ST_SCAN;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (grant_go) begin
            if (pend_q) begin
              out_num_q   <= pend_num_q;
              out_grant_q <= 1'b1;
              out_last_q  <= 1'b0;
            end
            pend_q      <= 1'b1;
            pend_num_q  <= {1'b0, row_q, pos} + CountW'(1);
            word_q[pos] <= 1'b1;
            want_q      <= want_q - ReqW'(1);
          end else if (scan_end) begin
            if (scan_stop) begin
              state_q <= ST_DONE;
            end else begin
              row_q   <= row_next[RowW-1:0];
              state_q <= ST_LOAD;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_num_q   <= pend_q ? pend_num_q : '0;
            out_grant_q <= pend_q;
            out_last_q  <= 1'b1;
            pend_q      <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(16-CountW){1'b0}}, out_num_q};
  assign m_axis_tuser_o  = out_grant_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTH
  a_want_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (want_q <= MaxRequestC))
    else $error("allocation count above limit");

  a_grant_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_grant_q) |-> (out_num_q != '0))
    else $error("granted block number is zero");

  a_pend_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_SCAN || state_q == ST_DONE || state_q == ST_LOAD))
    else $error("pending grant outside an allocation");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_req.we)
    else $error("bitmap write while idle");
`endif

endmodule

FILE: tb/bitmap_block_allocator_top_test.sv
// Self-checking testbench for the bitmap block allocator: queued stimulus, prediction, checks.
`timescale 1ns / 1ps
module bitmap_block_allocator_top_test;
  import bba_pkg::*;

  localparam int unsigned CycleLimit  = 1500000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles  = 500;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic [ReqW-1:0] count;
    op_e             op;
  } request_t;

  typedef struct packed {
    logic [CountW-1:0] number;
    logic              granted;
    logic              last;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid = 1'b0;
  logic [23:0] req_data = '0;
  logic [1:0]  req_user = '0;
  logic        res_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [12:0] cfg_data = '0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [15:0] m_axis_tdata_o;
  wire         m_axis_tuser_o;
  wire         m_axis_tlast_o;
  wire         cfg_ready_o;

  // predictor state
  bit                used_map [MaxBlocks];
  logic [CountW-1:0] limit_reg = MaxBlocksC;

  request_t    pending_q [$];
  grant_t      grant_q [$];
  request_t    req_cur;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_armed = 1'b0;
  int unsigned hold_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  bitmap_block_allocator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (req_data),
    .s_axis_tuser_i  (req_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // First-fit over the managed range; queues the grants that one request yields.
  function automatic void book_request(request_t r);
    int unsigned n;
    int unsigned want;
    int unsigned hits [$];
    grant_t      g;
    n = (limit_reg > MaxBlocks) ? MaxBlocks : int'(limit_reg);
    case (r.op)
      OP_ALLOC: begin
        want = (r.count > MaxRequestC) ? int'(MaxRequestC) : int'(r.count);
        for (int unsigned i = 0; i < n && hits.size() < want; i++) begin
          if (!used_map[i]) begin
            used_map[i] = 1'b1;
            hits.push_back(i + 1);
          end
        end
        if (hits.size() == 0) begin
          g = '{number: '0, granted: 1'b0, last: 1'b1};
          grant_q.push_back(g);
        end
        foreach (hits[k]) begin
          g = '{number: CountW'(hits[k]), granted: 1'b1, last: (k == hits.size() - 1)};
          grant_q.push_back(g);
        end
      end
      OP_FREE: begin
        if (r.index < n) used_map[r.index] = 1'b0;
      end
      OP_CLEAR: begin
        for (int unsigned i = 0; i < n; i++) used_map[i] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic request_t make_request(op_e op, int unsigned cnt, int unsigned idx);
    request_t r;
    r.op    = op;
    r.count = ReqW'(cnt);
    r.index = IdxW'(idx);
    return r;
  endfunction

  // Allocations outweigh frees unless free_pct is high; frees aimed low half the time so they hit used blocks.
  function automatic request_t random_request(int unsigned free_pct, int unsigned idx_hi);
    int unsigned roll;
    request_t    r;
    roll = $urandom_range(99);
    r = make_request(OP_ALLOC, $urandom_range(31), $urandom_range(4095));
    if (roll < 3) begin
      r.op = OP_NONE;
    end else if (roll < 7) begin
      r.op = OP_CLEAR;
    end else if (roll < 7 + free_pct) begin
      r.op = OP_FREE;
      if ($urandom_range(1)) r.index = IdxW'($urandom_range(idx_hi));
    end else if ($urandom_range(99) < 85) begin
      r.count = ReqW'($urandom_range(16));
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic drain;
    while (pending_q.size() != 0 || req_valid || grant_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic program_limit(logic [12:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_reg = value;
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_data  <= '0;
      req_user  <= '0;
    end else begin
      if (req_valid && s_axis_tready_o) book_request(req_cur);
      if (!req_valid || s_axis_tready_o) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_cur = pending_q.pop_front();
          req_valid <= 1'b1;
          req_data  <= {7'b0, req_cur.index, req_cur.count};
          req_user  <= req_cur.op;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk_i) begin
    if (hold_armed && hold_count < HoldCycles) begin
      hold_count <= hold_count + 1;
    end
  end

  // result monitor and backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t g;
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && res_ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result, block_number %0d",
                                    m_axis_tdata_o[CountW-1:0]));
        end else begin
          g = grant_q.pop_front();
          if (m_axis_tdata_o[CountW-1:0] !== g.number)
            report_mismatch($sformatf("block_number %0d, expected %0d",
                                      m_axis_tdata_o[CountW-1:0], g.number));
          if (m_axis_tuser_o !== g.granted)
            report_mismatch($sformatf("granted %b, expected %b", m_axis_tuser_o, g.granted));
          if (m_axis_tlast_o !== g.last)
            report_mismatch($sformatf("last %b, expected %b", m_axis_tlast_o, g.last));
        end
      end
      if (hold_armed && hold_count < HoldCycles) begin
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 24;
    recv_idle_pct = 61;

    // full range: zero count, saturation, refill of freed holes, ignored op
    program_limit(MaxBlocksC);
    @(negedge clk_i);
    pending_q.push_back(make_request(OP_ALLOC, 0, 0));
    pending_q.push_back(make_request(OP_ALLOC, 1, 0));
    pending_q.push_back(make_request(OP_ALLOC, 16, 4095));
    pending_q.push_back(make_request(OP_ALLOC, 31, 0));
    pending_q.push_back(make_request(OP_FREE, 0, 0));
    pending_q.push_back(make_request(OP_FREE, 31, 4095));
    pending_q.push_back(make_request(OP_FREE, 0, 5));
    pending_q.push_back(make_request(OP_ALLOC, 2, 0));
    pending_q.push_back(make_request(OP_NONE, 31, 4095));
    pending_q.push_back(make_request(OP_CLEAR, 0, 0));
    pending_q.push_back(make_request(OP_ALLOC, 12, 0));
    drain();

    // eight-block range: full map, out-of-range free, clear leaves upper bits alone
    program_limit(13'd8);
    pending_q.push_back(make_request(OP_ALLOC, 16, 0));
    pending_q.push_back(make_request(OP_FREE, 0, 9));
    pending_q.push_back(make_request(OP_FREE, 0, 3));
    pending_q.push_back(make_request(OP_ALLOC, 4, 0));
    pending_q.push_back(make_request(OP_CLEAR, 31, 4095));
    drain();

    // register above storage acts as the full map
    program_limit(13'h1FFF);
    pending_q.push_back(make_request(OP_ALLOC, 2, 0));
    pending_q.push_back(make_request(OP_ALLOC, 10, 0));
    drain();

    // no managed blocks at all
    program_limit(13'd0);
    pending_q.push_back(make_request(OP_ALLOC, 5, 0));
    pending_q.push_back(make_request(OP_FREE, 0, 0));
    pending_q.push_back(make_request(OP_CLEAR, 0, 0));
    drain();

    program_limit(MaxBlocksC);
    pending_q.push_back(make_request(OP_CLEAR, 0, 0));
    repeat (20) pending_q.push_back(random_request(25, 63));
    drain();

    program_limit(13'($urandom_range(8, 64)));
    repeat (20) pending_q.push_back(random_request(35, 63));
    drain();

    // fill every block up to number 4096, then churn the full map
    send_idle_pct = 61;
    recv_idle_pct = 24;
    program_limit(MaxBlocksC);
    pending_q.push_back(make_request(OP_CLEAR, $urandom_range(31), $urandom_range(4095)));
    repeat (MaxBlocks / 16)
      pending_q.push_back(make_request(OP_ALLOC, $urandom_range(16, 31), $urandom_range(4095)));
    pending_q.push_back(make_request(OP_ALLOC, $urandom_range(1, 16), $urandom_range(4095)));
    repeat (20) pending_q.push_back(random_request(50, 4095));
    drain();

    // no idling; long receiver hold-off backs up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_limit(13'($urandom_range(8, 8191)));
    repeat (30) pending_q.push_back(random_request(30, 255));
    hold_armed = 1'b1;
    drain();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
